// ===== rtl/core/hdmc_pkg.sv =====
// package for the hard-disk monte carlo move block: constants, item types, control structs
package hdmc_pkg;

	localparam int MAX_DISKS = 64;
	localparam int POS_BITS  = 24;
	localparam int HD_W      = $clog2(MAX_DISKS);
	localparam int CFG_W     = 24;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LOAD  = 2'd0;
	localparam mode_t MODE_TRIAL = 2'd1;
	localparam mode_t MODE_READ  = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BOX_SIZE    = 2'd0;
	localparam cfg_idx_t CFG_DISK_RADIUS = 2'd1;
	localparam cfg_idx_t CFG_MAX_SHIFT   = 2'd2;
	localparam cfg_idx_t CFG_DISK_COUNT  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  disk_index;
		logic [23:0] load_x;
		logic [23:0] load_y;
		logic [15:0] rand_x;
		logic [15:0] rand_y;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  result_index;
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic        accepted;
	} out_item_t;

	typedef struct packed {
		logic [POS_BITS-1:0] x;
		logic [POS_BITS-1:0] y;
	} pos_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

	typedef struct packed {
		logic clear;
		logic sample;
		logic skip;
	} ovl_ctl_t;

endpackage

// ===== rtl/core/hdmc_cell.sv =====
// one ring cell: holds a disk centre, takes its neighbor's centre on a shift
module hdmc_cell (
	input  logic                clk,
	input  hdmc_pkg::cell_ctl_t ctl,
	input  hdmc_pkg::pos_t      nbr,
	input  hdmc_pkg::pos_t      wr_pos,
	output hdmc_pkg::pos_t      pos
);

	hdmc_pkg::pos_t pos_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			pos_q <= wr_pos;
		end else if (ctl.shift) begin
			pos_q <= nbr;
		end
	end

	assign pos = pos_q;

endmodule

// ===== rtl/core/hdmc_overlap.sv =====
// overlap test pipeline: squared distance of candidate to the ring head, sticky hit flag
module hdmc_overlap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hdmc_pkg::ovl_ctl_t            ctl,
	input  hdmc_pkg::pos_t                cand,
	input  hdmc_pkg::pos_t                head,
	input  logic [2*hdmc_pkg::POS_BITS-1:0] lim,
	output logic                          hit
);

	localparam int PW = hdmc_pkg::POS_BITS;

	logic            v_s1, v_s2, hit_q;
	logic [PW-1:0]   dx_s1, dy_s1;
	logic [2*PW-1:0] sqx_s2, sqy_s2;
	logic [PW-1:0]   dx, dy;
	logic [2*PW:0]   sum;

	assign dx  = (cand.x > head.x) ? (cand.x - head.x) : (head.x - cand.x);
	assign dy  = (cand.y > head.y) ? (cand.y - head.y) : (head.y - cand.y);
	assign sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= ctl.sample && !ctl.skip;
			v_s2 <= v_s1;
			if (ctl.clear) begin
				hit_q <= 1'b0;
			end else if (v_s2 && (sum < {1'b0, lim})) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx;
		dy_s1  <= dy;
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
	end

	assign hit = hit_q;

endmodule

// ===== rtl/core/hard_disk_monte_carlo_move.sv =====
// top level: ring of disk cells, trial move unit, overlap pipeline and item control
// seek: the ring shifts until the addressed disk (disk_index) is at the ring head
// load and read: seek, then the result; trial: seek, CALC1, CALC2, a scan of the whole ring, drain, result
// a new item is taken only once the block is back in idle (in_stall is high until then);
// the next item is taken while the previous result waits
// reset: control cleared, registers to their defaults, disk centres undefined until loaded
module hard_disk_monte_carlo_move (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  hdmc_pkg::in_item_t        in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output hdmc_pkg::out_item_t       out_data,
	input  logic                      cfg_we,
	input  hdmc_pkg::cfg_idx_t        cfg_index,
	input  logic [hdmc_pkg::CFG_W-1:0] cfg_data
);

	localparam int PW = hdmc_pkg::POS_BITS;
	localparam int HW = hdmc_pkg::HD_W;
	localparam int ND = hdmc_pkg::MAX_DISKS;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SEEK  = 7'b0000010,
		ST_CALC1 = 7'b0000100,
		ST_CALC2 = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t              state_q, state_d;
	hdmc_pkg::in_item_t  item_q;
	hdmc_pkg::out_item_t out_q, res;
	logic                out_valid_q;
	logic [HW-1:0]       hd_q, sc_q, idx_h;
	logic                dr_q;
	logic [23:0]         box_q;
	logic [22:0]         rad_q, ms_q;
	logic [6:0]          dc_q;
	logic [2*PW-1:0]     lim_q;
	logic [PW-1:0]       scl_x_q, scl_y_q;
	hdmc_pkg::pos_t      cand_q, wr_pos, cand_d;
	hdmc_pkg::pos_t      cpos [ND];
	hdmc_pkg::ovl_ctl_t  ovl_ctl;
	logic                hit, idx_ok, at_idx, is_trial, is_load, out_free;
	logic                shift_en, wr_en, keep;
	logic [39:0]         prod_x, prod_y;
	logic [23:0]         dia;

	function automatic logic [PW-1:0] clamp_pos(input logic [PW-1:0] p0,
		input logic [PW-1:0] scl, input logic [22:0] ms, input logic [23:0] box);
		logic [PW+1:0] t;
		t = (PW+2)'(p0) + (PW+2)'(scl) - (PW+2)'(ms);
		if (t[PW+1]) begin
			clamp_pos = '0;
		end else if (t > (PW+2)'(box)) begin
			clamp_pos = PW'(box);
		end else begin
			clamp_pos = t[PW-1:0];
		end
	endfunction

	assign idx_h    = HW'(item_q.disk_index);
	assign idx_ok   = int'(item_q.disk_index) < ND;
	assign at_idx   = hd_q == idx_h;
	assign is_trial = item_q.mode == hdmc_pkg::MODE_TRIAL;
	assign is_load  = item_q.mode == hdmc_pkg::MODE_LOAD;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;
	assign keep     = idx_ok && (is_load || (is_trial && !hit));
	assign shift_en = ((state_q == ST_SEEK) && idx_ok && !at_idx) || (state_q == ST_SCAN);
	assign wr_en    = (state_q == ST_DONE) && out_free && keep;

	assign wr_pos.x = is_load ? PW'(item_q.load_x) : cand_q.x;
	assign wr_pos.y = is_load ? PW'(item_q.load_y) : cand_q.y;

	assign dia    = {rad_q, 1'b0};
	assign prod_x = {ms_q, 1'b0} * item_q.rand_x;
	assign prod_y = {ms_q, 1'b0} * item_q.rand_y;

	assign cand_d.x = clamp_pos(cpos[0].x, scl_x_q, ms_q, box_q);
	assign cand_d.y = clamp_pos(cpos[0].y, scl_y_q, ms_q, box_q);

	assign ovl_ctl.clear  = state_q == ST_CALC1;
	assign ovl_ctl.sample = state_q == ST_SCAN;
	assign ovl_ctl.skip   = (hd_q == idx_h) || (int'(hd_q) >= int'(dc_q));

	// ring of cells, head at cell 0
	for (genvar p = 0; p < ND; p++) begin : g_cell
		hdmc_pkg::cell_ctl_t cctl;
		assign cctl.shift = shift_en;
		assign cctl.wr    = (p == 0) && wr_en;
		hdmc_cell u_cell (
			.clk    (clk),
			.ctl    (cctl),
			.nbr    (cpos[(p + 1) % ND]),
			.wr_pos (wr_pos),
			.pos    (cpos[p])
		);
	end

	hdmc_overlap u_overlap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ovl_ctl),
		.cand   (cand_q),
		.head   (cpos[0]),
		.lim    (lim_q),
		.hit    (hit)
	);

	always_comb begin
		res.result_index = item_q.disk_index;
		res.accepted     = idx_ok && is_trial && !hit;
		if (!idx_ok) begin
			res.pos_x = '0;
			res.pos_y = '0;
		end else if (keep) begin
			res.pos_x = 24'(wr_pos.x);
			res.pos_y = 24'(wr_pos.y);
		end else begin
			res.pos_x = 24'(cpos[0].x);
			res.pos_y = 24'(cpos[0].y);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SEEK;
			end
			ST_SEEK: begin
				if (!idx_ok) state_d = ST_DONE;
				else if (at_idx) state_d = is_trial ? ST_CALC1 : ST_DONE;
			end
			ST_CALC1: state_d = ST_CALC2;
			ST_CALC2: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sc_q == HW'(ND - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (dr_q) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hd_q        <= '0;
			sc_q        <= '0;
			dr_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				hd_q <= (hd_q == HW'(ND - 1)) ? '0 : hd_q + 1'b1;
			end
			if (state_q == ST_CALC2) begin
				sc_q <= '0;
			end else if (state_q == ST_SCAN) begin
				sc_q <= sc_q + 1'b1;
			end
			dr_q <= (state_q == ST_DRAIN) ? !dr_q : 1'b0;
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= 24'd4194304;
			rad_q <= 23'd4096;
			ms_q  <= 23'd2048;
			dc_q  <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				hdmc_pkg::CFG_BOX_SIZE:    box_q <= cfg_data;
				hdmc_pkg::CFG_DISK_RADIUS: rad_q <= cfg_data[22:0];
				hdmc_pkg::CFG_MAX_SHIFT:   ms_q  <= cfg_data[22:0];
				hdmc_pkg::CFG_DISK_COUNT:  dc_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == ST_CALC1) begin
			scl_x_q <= PW'(prod_x[39:16]);
			scl_y_q <= PW'(prod_y[39:16]);
			lim_q   <= (2*PW)'(dia) * (2*PW)'(dia);
		end
		if (state_q == ST_CALC2) begin
			cand_q <= cand_d;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished item");

	a_scan_rotates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (hd_q != $past(hd_q)))
		else $error("ring head did not advance during scan");

	a_done_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && idx_ok) |-> at_idx)
		else $error("addressed disk not at ring head when finishing");

endmodule
